FILE: rtl/lazy_range_add_point_query_assert.svh
// Assertion macros shared by the lazy range-add checker.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef LAZY_RANGE_ADD_POINT_QUERY_ASSERT_SVH
`define LAZY_RANGE_ADD_POINT_QUERY_ASSERT_SVH

// same-cycle implication
`define LRAPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRAPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lrapq_pkg.sv
// Package for the lazy range-add / point-query block.
// Holds the controller state type and fixed field widths; no dependencies.
`timescale 1ns / 1ps

package lrapq_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned START_W = 10;
  localparam int unsigned END_W   = 11;

  typedef enum logic [6:0] {
    ST_CLR    = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_ADD    = 7'b0000100,
    ST_ADD_WR = 7'b0001000,
    ST_Q_RD   = 7'b0010000,
    ST_Q_ACC  = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_e;

endpackage

FILE: rtl/lrapq_ram.sv
// Generic single-port-write / single-port-read RAM with registered read.
// Standalone; used for the node add store.
`timescale 1ns / 1ps

module lrapq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lazy_range_add_point_query.sv
// Range-add / point-query store over LEAVES signed 64-bit elements.
// Depends on lrapq_pkg and lrapq_ram.
`timescale 1ns / 1ps

// After reset the block sweeps all 2*LEAVES entries of its node memory (2048
// at the default) to zero, one entry per cycle, with in_ready_o low. Each tree
// node holds the total of the adds that cover it exactly; adds are never
// pushed down, since a point's value is simply the sum of the nodes on its
// leaf-to-root path, which gives the same answers as a lazy tree. A range add
// walks the tree bottom-up and does a read-modify-write of the one or two
// border nodes at each level, reading each node in ST_ADD and writing the
// sum back in ST_ADD_WR. A query of a point within the array reads the
// log2(LEAVES)+1 nodes on its path, one per cycle through the memory read
// port, then adds the last word in ST_Q_ACC once the output register is
// free; a query beyond the array returns zero. One word is worked on at a
// time; a finished result sits in the output register while the next input
// word is taken. Sums wrap modulo 2^64.
module lazy_range_add_point_query #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic [lrapq_pkg::START_W-1:0]      range_start_i,
  input  logic [lrapq_pkg::END_W-1:0]        range_end_i,
  input  logic signed [lrapq_pkg::DATA_W-1:0] addend_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [lrapq_pkg::DATA_W-1:0] point_value_o
);

  localparam int unsigned LW    = $clog2(LEAVES);
  localparam int unsigned AW    = LW + 1;          // node address
  localparam int unsigned NW    = LW + 2;          // border pointers reach 2*LEAVES
  localparam int unsigned DEPTH = 2 * LEAVES;
  localparam int unsigned CW    = (NW > 12) ? NW : 12;  // compare width
  localparam int unsigned DW    = lrapq_pkg::DATA_W;

  lrapq_pkg::state_e state_q, state_d;

  logic [NW-1:0] lo_q, lo_d, hi_q, hi_d;   // half-open border pointers
  logic [AW-1:0] node_q, node_d;           // node under RMW or query walk
  logic [AW-1:0] clr_q, clr_d;
  logic [DW-1:0] x_q, x_d;
  logic [DW-1:0] acc_q, acc_d;
  logic          pend_q, pend_d;           // a query read is in flight
  logic          zero_q, zero_d;           // query beyond the array
  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] out_q, out_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic [CW-1:0] start_c, end_c, leaves_c;
  logic          accept;
  logic          out_free;

  assign start_c  = CW'(range_start_i);
  assign end_c    = (CW'(range_end_i) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(range_end_i);
  assign leaves_c = CW'(LEAVES);
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o    = (state_q == lrapq_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign point_value_o = out_q;

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    node_d      = node_q;
    clr_d       = clr_q;
    x_d         = x_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = node_q;
    wdata       = rdata + x_q;
    re          = 1'b0;
    raddr       = node_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      lrapq_pkg::ST_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = lrapq_pkg::ST_IDLE;
        end
      end
      lrapq_pkg::ST_IDLE: begin
        if (accept) begin
          x_d = addend_i;
          if (!mode_i) begin
            if (start_c < leaves_c && end_c > start_c) begin
              lo_d    = NW'(start_c) + NW'(LEAVES);
              hi_d    = NW'(end_c) + NW'(LEAVES);
              state_d = lrapq_pkg::ST_ADD;
            end
          end else begin
            acc_d  = '0;
            pend_d = 1'b0;
            if (start_c < leaves_c) begin
              zero_d  = 1'b0;
              node_d  = AW'(start_c) + AW'(LEAVES);
              state_d = lrapq_pkg::ST_Q_RD;
            end else begin
              zero_d  = 1'b1;
              state_d = lrapq_pkg::ST_Q_ACC;
            end
          end
        end
      end
      lrapq_pkg::ST_ADD: begin
        // bottom-up cover: odd left border and odd right border are full nodes
        if (lo_q >= hi_q) begin
          state_d = lrapq_pkg::ST_IDLE;
        end else if (lo_q[0]) begin
          re      = 1'b1;
          raddr   = lo_q[AW-1:0];
          node_d  = lo_q[AW-1:0];
          lo_d    = lo_q + 1'b1;
          state_d = lrapq_pkg::ST_ADD_WR;
        end else if (hi_q[0]) begin
          re      = 1'b1;
          raddr   = AW'(hi_q - 1'b1);
          node_d  = AW'(hi_q - 1'b1);
          hi_d    = hi_q - 1'b1;
          state_d = lrapq_pkg::ST_ADD_WR;
        end else begin
          lo_d = lo_q >> 1;
          hi_d = hi_q >> 1;
        end
      end
      lrapq_pkg::ST_ADD_WR: begin
        we      = 1'b1;
        state_d = lrapq_pkg::ST_ADD;
      end
      lrapq_pkg::ST_Q_RD: begin
        re     = 1'b1;
        pend_d = 1'b1;
        acc_d  = acc_q + (pend_q ? rdata : '0);
        if (node_q == AW'(1)) begin
          state_d = lrapq_pkg::ST_Q_ACC;
        end else begin
          node_d = node_q >> 1;
        end
      end
      lrapq_pkg::ST_Q_ACC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = zero_q ? '0 : acc_q + rdata;
          state_d     = lrapq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrapq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrapq_pkg::ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      zero_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      zero_q      <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    node_q <= node_d;
    x_q    <= x_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  lrapq_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

FILE: rtl/lrapq_checker.sv
// Port-level checker for the lazy range-add block, bound to the top level.
// Depends on lrapq_pkg widths and the assertion macro header.
`timescale 1ns / 1ps
`include "lazy_range_add_point_query_assert.svh"

module lrapq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                mode_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [lrapq_pkg::DATA_W-1:0] point_value_o
);

  `LRAPQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(point_value_o), "result word dropped or changed while stalled")
  `LRAPQ_ASSERT_NEXT(a_busy_after_query, in_valid_i && in_ready_o && mode_i, !in_ready_o, "took a second word before finishing a query")
  `LRAPQ_ASSERT_NEXT(a_add_no_result, in_valid_i && in_ready_o && !mode_i && !out_valid_o, !out_valid_o, "range add produced a result word")

endmodule

bind lazy_range_add_point_query lrapq_checker u_lrapq_checker (.*);
